// ----- design/ugeb_pkg.sv -----
// shared types and constants for the uniform grid entity binning block
// no dependencies

package ugeb_pkg;

  localparam int OPC_W      = 3;
  localparam int ID_W       = 10;
  localparam int POS_W      = 20;
  localparam int COORD_W    = POS_W + 1;
  localparam int IDX_W      = 12;
  localparam int GW_W       = 16;
  localparam int CNT_W      = 13;
  localparam int STAT_W     = 2;
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 40;

  localparam logic [GW_W-1:0]  GW_RESET  = 16'd1600;
  localparam logic [CNT_W-1:0] COUNT_MAX = 13'd8191;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVF   = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  typedef enum logic [OPC_W-1:0] {
    OP_CLEAR     = 3'd0,
    OP_ADD       = 3'd1,
    OP_BUILD     = 3'd2,
    OP_READ_CELL = 3'd3,
    OP_READ_SLOT = 3'd4
  } op_e;

endpackage

// ----- design/ugeb_div.sv -----
// shared restoring divider: cell = min(floor(coord*cells/(grid_width*16)), cells-1)
// one quotient bit per cycle; depends on ugeb_pkg

module ugeb_div import ugeb_pkg::*; #(
  parameter int CELLS_PER_ROW = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [COORD_W-1:0]               coord_i,
  input  logic [GW_W-1:0]                  grid_width_i,
  output logic                             done_o,
  output logic [$clog2(CELLS_PER_ROW)-1:0] cell_o
);

  localparam int CW  = $clog2(CELLS_PER_ROW);
  localparam int NW  = COORD_W + CW;
  localparam int SCW = $clog2(CW + 1);

  logic           busy_q, busy_d;
  logic           done_q, done_d;
  logic [NW-1:0]  rem_q, rem_d;
  logic [NW-1:0]  den_q, den_d;
  logic [CW-1:0]  quo_q, quo_d;
  logic [CW-1:0]  res_q, res_d;
  logic [SCW-1:0] cnt_q, cnt_d;

  logic [NW-1:0]  num;
  logic [NW-1:0]  den;
  logic [NW-1:0]  lim;
  logic           ge;

  assign num = NW'(32'(coord_i) * CELLS_PER_ROW);
  assign den = NW'({grid_width_i, 4'b0000});
  assign lim = NW'(32'({grid_width_i, 4'b0000}) * (CELLS_PER_ROW - 1));
  assign ge  = rem_q >= den_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    res_d  = res_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      if (den == '0 || num >= lim) begin
        res_d  = CW'(CELLS_PER_ROW - 1);
        done_d = 1'b1;
      end else begin
        busy_d = 1'b1;
        rem_d  = num;
        den_d  = den << (CW - 1);
        quo_d  = '0;
        cnt_d  = SCW'(CW);
      end
    end else if (busy_q) begin
      rem_d = ge ? rem_q - den_q : rem_q;
      den_d = den_q >> 1;
      quo_d = CW'({quo_q, ge});
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == SCW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        res_d  = quo_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign cell_o = res_q;

endmodule

// ----- design/uniform_grid_entity_binning.sv -----
// top level of the uniform grid entity binning block: sequencer, stores, stream ports
// depends on ugeb_pkg and ugeb_div

// One item is taken at a time and s_axis_tready_o is low while it is worked on; a result
// register lets the next item in while the last result waits. An add entity uses the one
// shared divider, which maps the four box edges to cells one quotient bit a cycle; a build
// zeroes the count and fill stores, then runs a count pass over the entities, a prefix pass
// over the cells and a scatter pass over the entities, with a single-port read-modify-write
// of the cell stores per covered cell in each of the count and scatter passes; read cell and
// read slot read the cell and slot stores; clear sweeps the entity and cell stores. After
// reset the same sweep runs before the first item is taken; grid width writes are taken at
// any time.

module uniform_grid_entity_binning import ugeb_pkg::*; #(
  parameter int CELLS_PER_ROW = 16,
  parameter int MAX_ENTITIES  = 1024,
  parameter int TABLE_SLOTS   = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [GW_W-1:0]       cfg_data_i,       // grid_width
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // id, pos_x, pos_y, size_x, size_y, read_index
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  input  logic [OPC_W-1:0]      s_axis_tuser_i,   // opcode
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // status, cell_offset, cell_length, slot_entity
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  localparam int CW  = $clog2(CELLS_PER_ROW);
  localparam int NC  = CELLS_PER_ROW * CELLS_PER_ROW;
  localparam int CIW = $clog2(NC);
  localparam int EIW = $clog2(MAX_ENTITIES);
  localparam int SIW = $clog2(TABLE_SLOTS);
  localparam int SW  = SIW + 1;
  localparam int AW  = CIW + CNT_W;
  localparam int IW  = ((SW > CNT_W) ? SW : CNT_W) + 1;
  localparam int PW  = 4 * CW;

  typedef enum logic [14:0] {
    S_CLR_ENT  = 15'h0001,
    S_CLR_CELL = 15'h0002,
    S_IDLE     = 15'h0004,
    S_ADD_GO   = 15'h0008,
    S_ADD_WAIT = 15'h0010,
    S_ADD_WR   = 15'h0020,
    S_ZERO     = 15'h0040,
    S_ENT_RD   = 15'h0080,
    S_ENT_CHK  = 15'h0100,
    S_CELL_RD  = 15'h0200,
    S_CELL_WR  = 15'h0400,
    S_PRE_RD   = 15'h0800,
    S_PRE_WR   = 15'h1000,
    S_RD       = 15'h2000,
    S_RESP     = 15'h4000
  } state_e;

  state_e state_q, state_d;

  logic [GW_W-1:0]         gw_q;
  logic [EIW-1:0]          ea_q, ea_d;
  logic [CIW-1:0]          ca_q, ca_d;
  logic [SIW-1:0]          ra_q, ra_d;
  logic [1:0]              k_q, k_d;
  logic [3:0][CW-1:0]      spn_q, spn_d;
  logic [CW-1:0]           x_q, x_d, y_q, y_d, x0_q, x0_d, x1_q, x1_d, y1_q, y1_d;
  logic [AW-1:0]           accum_q, accum_d;
  logic                    pass_q, pass_d;
  logic                    ovf_q, ovf_d;
  logic                    clr_op_q, clr_op_d;
  logic [STAT_W-1:0]       status_q, status_d;
  op_e                     op_q, op_d;
  logic [POS_W-1:0]        px_q, px_d, py_q, py_d, sx_q, sx_d, sy_q, sy_d;
  logic                    m_valid_q, m_valid_d;
  logic [OUT_DATA_W-1:0]   m_data_q, m_data_d;

  logic [PW:0]             ent_mem [MAX_ENTITIES];
  logic [CNT_W-1:0]        cnt_mem [NC];
  logic [CNT_W-1:0]        fil_mem [NC];
  logic [SW-1:0]           start_mem [NC];
  logic [ID_W-1:0]         slot_mem [TABLE_SLOTS];

  logic [PW:0]             ent_rd, ent_wd;
  logic [CNT_W-1:0]        cnt_rd, cnt_wd, fil_rd, fil_wd;
  logic [SW-1:0]           start_rd, start_wd, sat;
  logic [ID_W-1:0]         slot_rd;
  logic                    ent_we, cnt_we, fil_we, start_we, slot_we;
  logic [IW-1:0]           idx;
  logic                    fil_ok, idx_ok, adv_ent, ld_out, div_start, div_done;
  logic [CW-1:0]           div_cell;
  logic [COORD_W-1:0]      coord;
  logic [ID_W-1:0]         in_id;
  logic [IDX_W-1:0]        in_ri;
  logic                    e_last, c_last;
  logic [CNT_W-1:0]        out_off, out_len;
  logic [ID_W-1:0]         out_ent;

  function automatic logic [CIW-1:0] cell_idx(input logic [CW-1:0] y, input logic [CW-1:0] x);
    return CIW'(32'(y) * CELLS_PER_ROW + 32'(x));
  endfunction

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  assign in_id = s_axis_tdata_i[9:0];
  assign in_ri = s_axis_tdata_i[101:90];

  always_comb begin
    case (k_q)
      2'd0:    coord = COORD_W'(px_q);
      2'd1:    coord = COORD_W'(py_q);
      2'd2:    coord = COORD_W'(px_q) + COORD_W'(sx_q);
      default: coord = COORD_W'(py_q) + COORD_W'(sy_q);
    endcase
  end

  ugeb_div #(
    .CELLS_PER_ROW(CELLS_PER_ROW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .coord_i     (coord),
    .grid_width_i(gw_q),
    .done_o      (div_done),
    .cell_o      (div_cell)
  );

  assign e_last = (ea_q == EIW'(MAX_ENTITIES - 1));
  assign c_last = (ca_q == CIW'(NC - 1));
  assign fil_ok = fil_rd < cnt_rd;
  assign idx    = IW'(start_rd) + IW'(fil_rd);
  assign idx_ok = 32'(idx) < TABLE_SLOTS;
  assign sat    = (32'(accum_q) < TABLE_SLOTS) ? SW'(accum_q) : SW'(TABLE_SLOTS);

  assign ent_wd   = (state_q == S_ADD_WR) ? {1'b1, spn_q} : '0;
  assign cnt_wd   = (state_q == S_CELL_WR) ? cnt_rd + 1'b1 : '0;
  assign fil_wd   = (state_q == S_CELL_WR) ? fil_rd + 1'b1 : '0;
  assign start_wd = (state_q == S_PRE_WR) ? sat : '0;

  assign out_off = (op_q == OP_READ_CELL && status_q == ST_OK) ? CNT_W'(start_rd) : '0;
  assign out_len = (op_q == OP_READ_CELL && status_q == ST_OK) ? cnt_rd : '0;
  assign out_ent = (op_q == OP_READ_SLOT && status_q == ST_OK) ? slot_rd : '0;

  always_comb begin
    state_d   = state_q;
    ea_d      = ea_q;
    ca_d      = ca_q;
    ra_d      = ra_q;
    k_d       = k_q;
    spn_d     = spn_q;
    x_d       = x_q;
    y_d       = y_q;
    x0_d      = x0_q;
    x1_d      = x1_q;
    y1_d      = y1_q;
    accum_d   = accum_q;
    pass_d    = pass_q;
    ovf_d     = ovf_q;
    clr_op_d  = clr_op_q;
    status_d  = status_q;
    op_d      = op_q;
    px_d      = px_q;
    py_d      = py_q;
    sx_d      = sx_q;
    sy_d      = sy_q;
    ent_we    = 1'b0;
    cnt_we    = 1'b0;
    fil_we    = 1'b0;
    start_we  = 1'b0;
    slot_we   = 1'b0;
    div_start = 1'b0;
    adv_ent   = 1'b0;
    ld_out    = 1'b0;
    case (state_q)
      S_CLR_ENT: begin
        ent_we = 1'b1;
        if (e_last) begin
          ca_d    = '0;
          state_d = S_CLR_CELL;
        end else begin
          ea_d = ea_q + 1'b1;
        end
      end
      S_CLR_CELL: begin
        cnt_we   = 1'b1;
        fil_we   = 1'b1;
        start_we = 1'b1;
        if (c_last) begin
          state_d = clr_op_q ? S_RESP : S_IDLE;
        end else begin
          ca_d = ca_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          op_d     = op_e'(s_axis_tuser_i);
          status_d = ST_OK;
          px_d     = s_axis_tdata_i[29:10];
          py_d     = s_axis_tdata_i[49:30];
          sx_d     = s_axis_tdata_i[69:50];
          sy_d     = s_axis_tdata_i[89:70];
          state_d  = S_RESP;
          case (op_e'(s_axis_tuser_i))
            OP_CLEAR: begin
              ea_d     = '0;
              clr_op_d = 1'b1;
              ovf_d    = 1'b0;
              state_d  = S_CLR_ENT;
            end
            OP_ADD: begin
              if (32'(in_id) >= MAX_ENTITIES) begin
                status_d = ST_RANGE;
              end else begin
                ea_d    = EIW'(in_id);
                k_d     = 2'd0;
                state_d = S_ADD_GO;
              end
            end
            OP_BUILD: begin
              ca_d    = '0;
              ovf_d   = 1'b0;
              state_d = S_ZERO;
            end
            OP_READ_CELL: begin
              if (32'(in_ri) >= NC) begin
                status_d = ST_RANGE;
              end else begin
                ca_d    = CIW'(in_ri);
                state_d = S_RD;
              end
            end
            OP_READ_SLOT: begin
              if (32'(in_ri) >= TABLE_SLOTS) begin
                status_d = ST_RANGE;
              end else begin
                ra_d    = SIW'(in_ri);
                state_d = S_RD;
              end
            end
            default: state_d = S_RESP;
          endcase
        end
      end
      S_ADD_GO: begin
        div_start = 1'b1;
        state_d   = S_ADD_WAIT;
      end
      S_ADD_WAIT: begin
        if (div_done) begin
          spn_d[k_q] = div_cell;
          if (k_q == 2'd3) begin
            state_d = S_ADD_WR;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = S_ADD_GO;
          end
        end
      end
      S_ADD_WR: begin
        ent_we  = 1'b1;
        state_d = S_RESP;
      end
      S_ZERO: begin
        cnt_we = 1'b1;
        fil_we = 1'b1;
        if (c_last) begin
          ea_d    = '0;
          pass_d  = 1'b0;
          state_d = S_ENT_RD;
        end else begin
          ca_d = ca_q + 1'b1;
        end
      end
      S_ENT_RD: state_d = S_ENT_CHK;
      S_ENT_CHK: begin
        if (ent_rd[PW]) begin
          x0_d    = ent_rd[CW-1:0];
          x_d     = ent_rd[CW-1:0];
          y_d     = ent_rd[2*CW-1:CW];
          x1_d    = ent_rd[3*CW-1:2*CW];
          y1_d    = ent_rd[4*CW-1:3*CW];
          ca_d    = cell_idx(ent_rd[2*CW-1:CW], ent_rd[CW-1:0]);
          state_d = S_CELL_RD;
        end else begin
          adv_ent = 1'b1;
        end
      end
      S_CELL_RD: state_d = S_CELL_WR;
      S_CELL_WR: begin
        if (!pass_q) begin
          cnt_we = (cnt_rd != COUNT_MAX);
        end else begin
          fil_we  = fil_ok;
          slot_we = fil_ok && idx_ok;
          if (fil_ok && !idx_ok) ovf_d = 1'b1;
        end
        if (x_q != x1_q) begin
          x_d     = x_q + 1'b1;
          ca_d    = cell_idx(y_q, CW'(x_q + 1'b1));
          state_d = S_CELL_RD;
        end else if (y_q != y1_q) begin
          x_d     = x0_q;
          y_d     = y_q + 1'b1;
          ca_d    = cell_idx(CW'(y_q + 1'b1), x0_q);
          state_d = S_CELL_RD;
        end else begin
          adv_ent = 1'b1;
        end
      end
      S_PRE_RD: state_d = S_PRE_WR;
      S_PRE_WR: begin
        start_we = 1'b1;
        accum_d  = accum_q + AW'(cnt_rd);
        if (c_last) begin
          if (32'(accum_d) > TABLE_SLOTS) ovf_d = 1'b1;
          ea_d    = '0;
          pass_d  = 1'b1;
          state_d = S_ENT_RD;
        end else begin
          ca_d    = ca_q + 1'b1;
          state_d = S_PRE_RD;
        end
      end
      S_RD: state_d = S_RESP;
      S_RESP: begin
        if (!m_valid_q || m_axis_tready_i) begin
          ld_out   = 1'b1;
          clr_op_d = 1'b0;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (adv_ent) begin
      if (e_last) begin
        if (!pass_q) begin
          ca_d    = '0;
          accum_d = '0;
          state_d = S_PRE_RD;
        end else begin
          status_d = ovf_d ? ST_OVF : ST_OK;
          state_d  = S_RESP;
        end
      end else begin
        ea_d    = ea_q + 1'b1;
        state_d = S_ENT_RD;
      end
    end
  end

  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    if (ld_out) begin
      m_valid_d = 1'b1;
      m_data_d  = {2'b00, out_ent, out_len, out_off, status_q};
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR_ENT;
      gw_q      <= GW_RESET;
      ea_q      <= '0;
      ca_q      <= '0;
      pass_q    <= 1'b0;
      ovf_q     <= 1'b0;
      clr_op_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ea_q      <= ea_d;
      ca_q      <= ca_d;
      pass_q    <= pass_d;
      ovf_q     <= ovf_d;
      clr_op_q  <= clr_op_d;
      m_valid_q <= m_valid_d;
      if (cfg_valid_i) gw_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ra_q     <= ra_d;
    k_q      <= k_d;
    spn_q    <= spn_d;
    x_q      <= x_d;
    y_q      <= y_d;
    x0_q     <= x0_d;
    x1_q     <= x1_d;
    y1_q     <= y1_d;
    accum_q  <= accum_d;
    status_q <= status_d;
    op_q     <= op_d;
    px_q     <= px_d;
    py_q     <= py_d;
    sx_q     <= sx_d;
    sy_q     <= sy_d;
    m_data_q <= m_data_d;
  end

  // entity store: present bit and cell span
  always_ff @(posedge clk_i) begin
    if (ent_we) ent_mem[ea_q] <= ent_wd;
    ent_rd <= ent_mem[ea_q];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[ca_q] <= cnt_wd;
    cnt_rd <= cnt_mem[ca_q];
  end

  always_ff @(posedge clk_i) begin
    if (fil_we) fil_mem[ca_q] <= fil_wd;
    fil_rd <= fil_mem[ca_q];
  end

  always_ff @(posedge clk_i) begin
    if (start_we) start_mem[ca_q] <= start_wd;
    start_rd <= start_mem[ca_q];
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) slot_mem[SIW'(idx)] <= ID_W'(ea_q);
    slot_rd <= slot_mem[ra_q];
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input taken while an item is in work");

  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_ADD_WAIT))
    else $error("divider result outside add sequence");

  a_cell_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CELL_WR) |-> (32'(ca_q) < NC) && (x_q <= x1_q) && (y_q <= y1_q))
    else $error("cell walk left the entity span");
`endif

endmodule

// ----- verif/uniform_grid_entity_binning_tb.sv -----
// self-checking testbench for uniform_grid_entity_binning: directed and random streams
// of grid ops checked against an in-bench model of the binning; depends on ugeb_pkg and uniform_grid_entity_binning
`timescale 1ns / 1ps

module uniform_grid_entity_binning_tb;
  import ugeb_pkg::*;

  localparam int CELLS   = 16;
  localparam int NCELLS  = CELLS * CELLS;
  localparam int NENT    = 1024;
  localparam int NSLOTS  = 4096;
  localparam int LIMIT   = 20_000_000;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  offset;
    logic [CNT_W-1:0]  length;
    logic [ID_W-1:0]   entity;
  } bin_result_t;

  typedef struct packed {
    logic [7:0] x0, y0, x1, y1;
  } span_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [GW_W-1:0] cfg_data_i = '0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [IN_DATA_W-1:0] s_axis_tdata_i = '0;
  logic [OPC_W-1:0] s_axis_tuser_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  uniform_grid_entity_binning uut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i, .s_axis_tuser_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o
  );

  always #4 clk_i = ~clk_i;

  // model state
  logic [GW_W-1:0] grid_w;
  bit              ent_present [NENT];
  span_t           ent_span [NENT];
  int unsigned     cnt [NCELLS];
  int unsigned     start [NCELLS];
  int unsigned     filled [NCELLS];
  logic [ID_W-1:0] slots [NSLOTS];
  bit              slot_written [NSLOTS];
  int              written_list [$];
  bit              ovf;

  bin_result_t grid_expect_q [$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int builds_done = 0;
  int cycles = 0;
  int burst_left = 0;

  function automatic logic [7:0] cell_of(logic [COORD_W-1:0] c);
    longint unsigned den, q;
    den = longint'(grid_w) * 16;
    if (den == 0) return 8'(CELLS - 1);
    q = (longint'(c) * CELLS) / den;
    if (q > CELLS - 1) q = CELLS - 1;
    return 8'(q);
  endfunction

  task automatic build_bins();
    int unsigned accum;
    int unsigned c, idx;
    accum = 0;
    for (int i = 0; i < NCELLS; i++) begin
      cnt[i] = 0;
      filled[i] = 0;
    end
    ovf = 1'b0;
    for (int e = 0; e < NENT; e++)
      if (ent_present[e])
        for (int y = ent_span[e].y0; y <= ent_span[e].y1; y++)
          for (int x = ent_span[e].x0; x <= ent_span[e].x1; x++) begin
            c = y * CELLS + x;
            if (c < NCELLS && cnt[c] < COUNT_MAX) cnt[c]++;
          end
    for (int i = 0; i < NCELLS; i++) begin
      start[i] = accum < NSLOTS ? accum : NSLOTS;
      accum += cnt[i];
    end
    if (accum > NSLOTS) ovf = 1'b1;
    for (int e = 0; e < NENT; e++)
      if (ent_present[e])
        for (int y = ent_span[e].y0; y <= ent_span[e].y1; y++)
          for (int x = ent_span[e].x0; x <= ent_span[e].x1; x++) begin
            c = y * CELLS + x;
            if (c >= NCELLS || filled[c] >= cnt[c]) continue;
            idx = start[c] + filled[c];
            filled[c]++;
            if (idx < NSLOTS) begin
              slots[idx] = e[ID_W-1:0];
              if (!slot_written[idx]) begin
                slot_written[idx] = 1'b1;
                written_list.push_back(idx);
              end
            end else begin
              ovf = 1'b1;
            end
          end
  endtask

  task automatic predict_item(logic [OPC_W-1:0] op, logic [IN_DATA_W-1:0] d);
    bin_result_t r;
    logic [ID_W-1:0] id;
    logic [COORD_W-1:0] px, py, sx, sy;
    logic [IDX_W-1:0] ri;
    r = '0;
    id = d[9:0];
    px = COORD_W'(d[29:10]);
    py = COORD_W'(d[49:30]);
    sx = COORD_W'(d[69:50]);
    sy = COORD_W'(d[89:70]);
    ri = d[101:90];
    case (op)
      OP_CLEAR: begin
        for (int i = 0; i < NENT; i++) ent_present[i] = 1'b0;
        for (int i = 0; i < NCELLS; i++) begin
          cnt[i] = 0;
          start[i] = 0;
          filled[i] = 0;
        end
        ovf = 1'b0;
      end
      OP_ADD: begin
        ent_span[id] = '{cell_of(px), cell_of(py), cell_of(px + sx), cell_of(py + sy)};
        ent_present[id] = 1'b1;
      end
      OP_BUILD: begin
        build_bins();
        builds_done++;
        r.status = ovf ? ST_OVF : ST_OK;
      end
      OP_READ_CELL: begin
        if (ri >= NCELLS) begin
          r.status = ST_RANGE;
        end else begin
          r.offset = CNT_W'(start[ri]);
          r.length = CNT_W'(cnt[ri]);
        end
      end
      OP_READ_SLOT: begin
        if (ri >= NSLOTS) r.status = ST_RANGE;
        else r.entity = slots[ri];
      end
      default: ;
    endcase
    grid_expect_q.push_back(r);
  endtask

  function automatic logic [IN_DATA_W-1:0] pack_in(int id, int px, int py, int sx, int sy,
                                                   int ri);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[9:0] = id[9:0];
    d[29:10] = px[19:0];
    d[49:30] = py[19:0];
    d[69:50] = sx[19:0];
    d[89:70] = sy[19:0];
    d[101:90] = ri[11:0];
    return d;
  endfunction

  task automatic send_item(logic [OPC_W-1:0] op, logic [IN_DATA_W-1:0] d);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk_i);
        s_axis_tvalid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= op;
    s_axis_tdata_i <= d;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_item(op, d);
    items_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    burst_left = 0;
    while (grid_expect_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_grid_width(logic [GW_W-1:0] w);
    wait_idle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= w;
    do @(posedge clk_i); while (!cfg_ready_o);
    grid_w = w;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cfg_data_i <= GW_W'($urandom());
  endtask

  task automatic read_slot_any();
    int k;
    if (written_list.size() == 0) begin
      send_item(OP_READ_CELL, pack_in(0, 0, 0, 0, 0, $urandom_range(0, 4095)));
    end else begin
      k = written_list[$urandom_range(0, written_list.size() - 1)];
      send_item(OP_READ_SLOT, pack_in($urandom, $urandom, $urandom, $urandom, $urandom, k));
    end
  endtask

  task automatic test_after_reset();
    send_item(OP_READ_CELL, pack_in(0, 0, 0, 0, 0, 0));
    send_item(OP_READ_CELL, pack_in(0, 0, 0, 0, 0, NCELLS - 1));
    send_item(OP_READ_CELL, pack_in(0, 0, 0, 0, 0, NCELLS));
    send_item(OP_READ_CELL, pack_in(1023, 0, 0, 0, 0, 4095));
    for (int op = 5; op < 8; op++)
      send_item(OPC_W'(op), pack_in($urandom, $urandom, $urandom, $urandom, $urandom,
                                    $urandom));
  endtask

  task automatic test_add_build_read();
    send_item(OP_ADD, pack_in(0, 0, 0, 0, 0, 0));
    send_item(OP_ADD, pack_in(1023, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 0));
    send_item(OP_ADD, pack_in(5, 1600, 3200, 1599, 1600, 0));
    send_item(OP_ADD, pack_in(6, 0, 0, 20'hFFFFF, 0, 0));
    send_item(OP_ADD, pack_in(6, 0, 0, 0, 20'hFFFFF, 0));
    send_item(OP_BUILD, '0);
    send_item(OP_READ_CELL, pack_in(0, 0, 0, 0, 0, 0));
    send_item(OP_READ_CELL, pack_in(0, 0, 0, 0, 0, 34));
    send_item(OP_READ_CELL, pack_in(0, 0, 0, 0, 0, 255));
    for (int i = 0; i < 4; i++) read_slot_any();
    send_item(OP_CLEAR, '0);
    send_item(OP_READ_CELL, pack_in(0, 0, 0, 0, 0, 34));
    send_item(OP_BUILD, '0);
    read_slot_any();
  endtask

  task automatic test_overflow();
    send_item(OP_CLEAR, '0);
    for (int i = 0; i < 17; i++)
      send_item(OP_ADD, pack_in(i * 60, 0, 0, 20'hFFFFF, 20'hFFFFF, 0));
    send_item(OP_BUILD, '0);
    send_item(OP_READ_CELL, pack_in(0, 0, 0, 0, 0, 255));
    send_item(OP_READ_CELL, pack_in(0, 0, 0, 0, 0, 240));
    send_item(OP_READ_SLOT, pack_in(0, 0, 0, 0, 0, 4095));
    send_item(OP_READ_SLOT, pack_in(0, 0, 0, 0, 0, 0));
    send_item(OP_CLEAR, '0);
  endtask

  task automatic test_random();
    logic [GW_W-1:0] widths [5];
    int n_add, px, py, sx, sy;
    widths = '{16'd1600, 16'd1, 16'hFFFF, 16'd0, 16'd1};
    for (int ph = 0; items_sent < 1000 || ph < 8; ph++) begin
      widths[4] = GW_W'($urandom_range(1, 65535));
      write_grid_width(widths[ph % 5]);
      if ($urandom_range(0, 3) != 0) send_item(OP_CLEAR, '0);
      n_add = (widths[ph % 5] < 4) ? $urandom_range(1, 6) : $urandom_range(1, 25);
      for (int i = 0; i < n_add; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          px = $urandom;
          py = $urandom;
          sx = $urandom;
          sy = $urandom;
        end else begin
          px = $urandom_range(0, int'(widths[ph % 5]) * 16 + 16);
          py = $urandom_range(0, int'(widths[ph % 5]) * 16 + 16);
          sx = $urandom_range(0, int'(widths[ph % 5]) * 2);
          sy = $urandom_range(0, int'(widths[ph % 5]) * 2);
        end
        send_item(OP_ADD, pack_in($urandom_range(0, 1023), px, py, sx, sy, $urandom));
        if ($urandom_range(0, 15) == 0)
          send_item(OPC_W'($urandom_range(5, 7)), pack_in($urandom, $urandom, $urandom,
                                                        $urandom, $urandom, $urandom));
      end
      send_item(OP_BUILD, pack_in($urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
      for (int i = $urandom_range(4, 14); i > 0; i--) begin
        if ($urandom_range(0, 1) == 0)
          send_item(OP_READ_CELL, pack_in($urandom, $urandom, $urandom, $urandom, $urandom,
                    ($urandom_range(0, 7) == 0) ? $urandom_range(256, 4095)
                                                : $urandom_range(0, 255)));
        else
          read_slot_any();
      end
    end
  endtask

  // receiver stall pattern in one of four randomly chosen modes
  int rx_mode = 0;
  always @(negedge clk_i) begin
    if (cycles % 64 == 0) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0: m_axis_tready_i <= 1'b1;
      1: m_axis_tready_i <= ($urandom_range(0, 1) == 1);
      2: m_axis_tready_i <= ($urandom_range(0, 7) == 0);
      default: m_axis_tready_i <= ((cycles / 8) % 2 == 0);
    endcase
  end

  always @(posedge clk_i) begin
    bin_result_t got, exp_r;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("uniform_grid_entity_binning_tb: FAIL");
      $finish;
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.status = m_axis_tdata_o[1:0];
      got.offset = m_axis_tdata_o[14:2];
      got.length = m_axis_tdata_o[27:15];
      got.entity = m_axis_tdata_o[37:28];
      results_seen++;
      if (grid_expect_q.size() == 0) begin
        $error("result with no item pending: %h", m_axis_tdata_o);
        errors++;
      end else begin
        exp_r = grid_expect_q.pop_front();
        if (got.status !== exp_r.status) begin
          $error("status expected %0d got %0d", exp_r.status, got.status);
          errors++;
        end
        if (got.offset !== exp_r.offset) begin
          $error("cell_offset expected %0d got %0d", exp_r.offset, got.offset);
          errors++;
        end
        if (got.length !== exp_r.length) begin
          $error("cell_length expected %0d got %0d", exp_r.length, got.length);
          errors++;
        end
        if (got.entity !== exp_r.entity) begin
          $error("slot_entity expected %0d got %0d", exp_r.entity, got.entity);
          errors++;
        end
      end
    end
  end

  initial begin
    grid_w = GW_RESET;
    ovf = 1'b0;
    for (int i = 0; i < NENT; i++) begin
      ent_present[i] = 1'b0;
      ent_span[i] = '0;
    end
    for (int i = 0; i < NCELLS; i++) begin
      cnt[i] = 0;
      start[i] = 0;
      filled[i] = 0;
    end
    for (int i = 0; i < NSLOTS; i++) begin
      slots[i] = '0;
      slot_written[i] = 1'b0;
    end
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_after_reset();
    test_add_build_read();
    test_overflow();
    write_grid_width(16'd1);
    test_add_build_read();
    test_random();
    wait_idle();
    repeat (50) @(posedge clk_i);
    if (grid_expect_q.size() != 0) begin
      $error("%0d results never arrived", grid_expect_q.size());
      errors++;
    end
    $display("covered %0d items, %0d builds, %0d results, grid widths 0, 1, 1600, 65535 and random",
             items_sent, builds_done, results_seen);
    if (errors == 0) $display("uniform_grid_entity_binning_tb: PASS");
    else $display("uniform_grid_entity_binning_tb: FAIL");
    $finish;
  end

endmodule

// ----- uniform_grid_entity_binning.f -----
design/ugeb_pkg.sv
design/ugeb_div.sv
design/uniform_grid_entity_binning.sv
verif/uniform_grid_entity_binning_tb.sv
